// ----- rtl/svm_pkg.sv -----
// ----------------------------------------------------------------------------
// svm_pkg
// Shared types, constants and control structures of the sample voice mixer.
// ----------------------------------------------------------------------------
package svm_pkg;

  localparam int MAX_VOICES_DEF   = 64;
  localparam int SLOT_COUNT_DEF   = 1024;
  localparam int SAMPLE_WORDS_DEF = 65536;

  localparam int LEN_W = 17;
  localparam int PCM_W = 16;
  localparam int ACT_W = 7;

  localparam logic [LEN_W-1:0] LEN_CAP = 17'h10000;
  localparam logic signed [PCM_W-1:0] PCM_MIN = -16'sd32768;
  localparam logic signed [PCM_W-1:0] PCM_MAX = 16'sd32767;

  localparam logic [2:0] OP_WRITE_SAMPLE = 3'd0;
  localparam logic [2:0] OP_WRITE_SLOT   = 3'd1;
  localparam logic [2:0] OP_TRIGGER      = 3'd2;
  localparam logic [2:0] OP_MIX          = 3'd3;
  localparam logic [2:0] OP_STOP         = 3'd4;

  typedef struct packed {
    logic [2:0]              op;
    logic [15:0]             mem_address;
    logic signed [PCM_W-1:0] sample_value;
    logic [9:0]              slot_number;
    logic [15:0]             slot_base;
    logic [LEN_W-1:0]        slot_length;
    logic                    slot_stereo;
  } svm_in_t;

  typedef struct packed {
    logic signed [PCM_W-1:0] left_out;
    logic signed [PCM_W-1:0] right_out;
    logic [ACT_W-1:0]        voices_active;
  } svm_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SIMPLE,
    ST_TRIG_READ,
    ST_TRIG_WRITE,
    ST_VOICE_READ,
    ST_VOICE_LATCH,
    ST_SLOT_LATCH,
    ST_LEFT_READ,
    ST_RIGHT_READ,
    ST_VOICE_DONE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic clr_step;
    logic simple;
    logic trig_read;
    logic trig_write;
    logic voice_read;
    logic voice_latch;
    logic slot_latch;
    logic left_read;
    logic right_read;
    logic voice_done;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic       in_valid;
    logic [2:0] op;
    logic       count_zero;
    logic       last_voice;
    logic       out_free;
    logic       clr_last;
  } stat_t;

endpackage

// ----- rtl/svm_chan_if.sv -----
// ----------------------------------------------------------------------------
// svm_chan_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface svm_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/sample_voice_mixer.sv -----
// Sample write, slot write, stop and unknown ops go through ST_SIMPLE; a trigger goes
// through ST_TRIG_READ and ST_TRIG_WRITE. A mix beat runs the six-step voice walk per
// listed voice. One beat at a time; the next beat is taken once the sequencer is idle.
// The output register holds a finished frame while a new beat is accepted.
// Reset (synchronous) empties the voice list, then sweeps the slot table to zero
// in ST_CLEAR, during which no beat is accepted.
// ----------------------------------------------------------------------------
// sample_voice_mixer
// Polyphonic sample-playback mixer with sample store, slot table and voice list.
// ----------------------------------------------------------------------------
module sample_voice_mixer #(
  parameter int MAX_VOICES   = svm_pkg::MAX_VOICES_DEF,
  parameter int SLOT_COUNT   = svm_pkg::SLOT_COUNT_DEF,
  parameter int SAMPLE_WORDS = svm_pkg::SAMPLE_WORDS_DEF
) (
  input logic        clk,
  input logic        rst,
  svm_chan_if.sink   req,
  svm_chan_if.source mix
);
  svm_pkg::ctl_t  ctl;
  svm_pkg::stat_t stat;

  svm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .stat(stat), .ctl(ctl)
  );

  svm_dp #(
    .MAX_VOICES(MAX_VOICES), .SLOT_COUNT(SLOT_COUNT), .SAMPLE_WORDS(SAMPLE_WORDS)
  ) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .stat(stat), .req(req), .mix(mix)
  );
endmodule

// ----- rtl/svm_ram.sv -----
// ----------------------------------------------------------------------------
// svm_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module svm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/svm_ctrl.sv -----
// ----------------------------------------------------------------------------
// svm_ctrl
// Sequencer that steps the datapath through each operation.
// ----------------------------------------------------------------------------
module svm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  svm_pkg::stat_t stat,
  output svm_pkg::ctl_t  ctl
);
  svm_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= svm_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl = '0;
    unique case (state)
      svm_pkg::ST_CLEAR: begin
        ctl.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = svm_pkg::ST_IDLE;
        end
      end
      svm_pkg::ST_IDLE: begin
        ctl.in_ready = 1'b1;
        if (stat.in_valid) begin
          if (stat.op == svm_pkg::OP_TRIGGER) begin
            state_next = svm_pkg::ST_TRIG_READ;
          end else if (stat.op == svm_pkg::OP_MIX) begin
            state_next = stat.count_zero ? svm_pkg::ST_FINISH : svm_pkg::ST_VOICE_READ;
          end else begin
            state_next = svm_pkg::ST_SIMPLE;
          end
        end
      end
      svm_pkg::ST_SIMPLE: begin
        ctl.simple = 1'b1;
        state_next = svm_pkg::ST_IDLE;
      end
      svm_pkg::ST_TRIG_READ: begin
        ctl.trig_read = 1'b1;
        state_next = svm_pkg::ST_TRIG_WRITE;
      end
      svm_pkg::ST_TRIG_WRITE: begin
        ctl.trig_write = 1'b1;
        state_next = svm_pkg::ST_IDLE;
      end
      svm_pkg::ST_VOICE_READ: begin
        ctl.voice_read = 1'b1;
        state_next = svm_pkg::ST_VOICE_LATCH;
      end
      svm_pkg::ST_VOICE_LATCH: begin
        ctl.voice_latch = 1'b1;
        state_next = svm_pkg::ST_SLOT_LATCH;
      end
      svm_pkg::ST_SLOT_LATCH: begin
        ctl.slot_latch = 1'b1;
        state_next = svm_pkg::ST_LEFT_READ;
      end
      svm_pkg::ST_LEFT_READ: begin
        ctl.left_read = 1'b1;
        state_next = svm_pkg::ST_RIGHT_READ;
      end
      svm_pkg::ST_RIGHT_READ: begin
        ctl.right_read = 1'b1;
        state_next = svm_pkg::ST_VOICE_DONE;
      end
      svm_pkg::ST_VOICE_DONE: begin
        ctl.voice_done = 1'b1;
        state_next = stat.last_voice ? svm_pkg::ST_FINISH : svm_pkg::ST_VOICE_READ;
      end
      svm_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          ctl.finish = 1'b1;
          state_next = svm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = svm_pkg::ST_IDLE;
      end
    endcase
  end
endmodule

// ----- rtl/svm_dp.sv -----
// ----------------------------------------------------------------------------
// svm_dp
// Datapath: sample, slot and voice memories, voice walk and saturating mix.
// ----------------------------------------------------------------------------
module svm_dp #(
  parameter int MAX_VOICES   = svm_pkg::MAX_VOICES_DEF,
  parameter int SLOT_COUNT   = svm_pkg::SLOT_COUNT_DEF,
  parameter int SAMPLE_WORDS = svm_pkg::SAMPLE_WORDS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  svm_pkg::ctl_t  ctl,
  output svm_pkg::stat_t stat,
  svm_chan_if.sink       req,
  svm_chan_if.source     mix
);
  localparam int VIW = MAX_VOICES > 1 ? $clog2(MAX_VOICES) : 1;
  localparam int CW  = $clog2(MAX_VOICES + 1);
  localparam int SW  = $clog2(SLOT_COUNT);
  localparam int AW  = $clog2(SAMPLE_WORDS);
  localparam int LW  = svm_pkg::LEN_W;
  localparam int PW  = svm_pkg::PCM_W;
  localparam int SDW = 16 + LW + 1;
  localparam int VDW = SW + LW;

  function automatic logic [AW-1:0] wrap_addr(input logic [17:0] s);
    logic [40:0] v;
    v = 41'(s);
    for (int k = 7; k >= 0; k--) begin
      if (v >= (41'(SAMPLE_WORDS) << k)) begin
        v = v - (41'(SAMPLE_WORDS) << k);
      end
    end
    return v[AW-1:0];
  endfunction

  function automatic logic [VIW-1:0] ring(input logic [VIW-1:0] h, input logic [CW-1:0] x);
    logic [CW:0] s;
    s = (CW+1)'(h) + (CW+1)'(x);
    if (s >= (CW+1)'(MAX_VOICES)) begin
      s = s - (CW+1)'(MAX_VOICES);
    end
    return s[VIW-1:0];
  endfunction

  function automatic logic signed [PW-1:0] sat_add(input logic signed [PW-1:0] a,
                                                   input logic signed [PW-1:0] b);
    logic signed [PW:0] s;
    s = (PW+1)'(a) + (PW+1)'(b);
    if (s > (PW+1)'(svm_pkg::PCM_MAX)) begin
      return svm_pkg::PCM_MAX;
    end else if (s < (PW+1)'(svm_pkg::PCM_MIN)) begin
      return svm_pkg::PCM_MIN;
    end
    return s[PW-1:0];
  endfunction

  svm_pkg::svm_in_t cur;
  svm_pkg::svm_out_t out_data;
  logic              out_valid;
  logic [VIW-1:0]    head;
  logic [CW-1:0]     count, idx, kept;
  logic [SW-1:0]     clr_idx, vslot;
  logic [LW-1:0]     vpos, slen;
  logic [15:0]       sbase;
  logic              sstereo;
  logic signed [PW-1:0] acc_l, acc_r, lword;

  logic             accept;
  logic             slot_ok, full, trig_ok, active, right_ok, keep;
  logic [SW-1:0]    cur_slot;
  logic [LW-1:0]    cap_len, new_pos;
  logic signed [PW-1:0] rv;

  logic             samp_we, slot_we, voice_we;
  logic [AW-1:0]    samp_waddr, samp_raddr;
  logic [PW-1:0]    samp_rdata;
  logic [SW-1:0]    slot_waddr, slot_raddr;
  logic [SDW-1:0]   slot_wdata, slot_rdata;
  logic [VIW-1:0]   voice_waddr, voice_raddr;
  logic [VDW-1:0]   voice_wdata, voice_rdata;

  assign accept   = req.valid && ctl.in_ready;
  assign req.ready = ctl.in_ready;
  assign mix.valid = out_valid;
  assign mix.data  = out_data;

  assign cur_slot = SW'(cur.slot_number);
  assign slot_ok  = 32'(cur.slot_number) < SLOT_COUNT;
  assign cap_len  = (cur.slot_length > svm_pkg::LEN_CAP) ? svm_pkg::LEN_CAP : cur.slot_length;
  assign full     = count == CW'(MAX_VOICES);
  assign trig_ok  = slot_ok && (cur.slot_number != '0) && (slot_rdata[LW:1] != '0);

  assign active   = vpos < slen;
  assign right_ok = (18'(vpos) + 18'd1) < 18'(slen);
  assign rv       = sstereo ? (right_ok ? samp_rdata : '0) : lword;
  assign new_pos  = vpos + (sstereo ? LW'(2) : LW'(1));
  assign keep     = active && (new_pos < slen);

  assign stat.in_valid   = req.valid;
  assign stat.op         = req.data.op;
  assign stat.count_zero = count == '0;
  assign stat.last_voice = (CW+1)'(idx) + (CW+1)'(1) == (CW+1)'(count);
  assign stat.out_free   = !out_valid || mix.ready;
  assign stat.clr_last   = clr_idx == SW'(SLOT_COUNT - 1);

  assign samp_we    = ctl.simple && (cur.op == svm_pkg::OP_WRITE_SAMPLE);
  assign samp_waddr = wrap_addr(18'(cur.mem_address));
  assign samp_raddr = ctl.left_read ? wrap_addr(18'(sbase) + 18'(vpos))
                                    : wrap_addr(18'(sbase) + 18'(vpos) + 18'd1);

  assign slot_we    = ctl.clr_step
                      || (ctl.simple && (cur.op == svm_pkg::OP_WRITE_SLOT) && slot_ok);
  assign slot_waddr = ctl.clr_step ? clr_idx : cur_slot;
  assign slot_wdata = ctl.clr_step ? '0 : {cur.slot_base, cap_len, cur.slot_stereo};
  assign slot_raddr = ctl.trig_read ? cur_slot : voice_rdata[VDW-1:LW];

  assign voice_we    = (ctl.trig_write && trig_ok) || (ctl.voice_done && keep);
  assign voice_waddr = ctl.trig_write ? ring(head, count) : ring(head, kept);
  assign voice_wdata = ctl.trig_write ? {cur_slot, LW'(0)} : {vslot, new_pos};
  assign voice_raddr = ring(head, idx);

  svm_ram #(.WIDTH(PW), .DEPTH(SAMPLE_WORDS)) u_samples (
    .clk(clk), .we(samp_we), .waddr(samp_waddr), .wdata(cur.sample_value),
    .raddr(samp_raddr), .rdata(samp_rdata)
  );

  svm_ram #(.WIDTH(SDW), .DEPTH(SLOT_COUNT)) u_slots (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rdata)
  );

  svm_ram #(.WIDTH(VDW), .DEPTH(MAX_VOICES)) u_voices (
    .clk(clk), .we(voice_we), .waddr(voice_waddr), .wdata(voice_wdata),
    .raddr(voice_raddr), .rdata(voice_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      count     <= '0;
      head      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.clr_step) begin
        clr_idx <= clr_idx + SW'(1);
      end
      if (ctl.simple && (cur.op == svm_pkg::OP_STOP)) begin
        count <= '0;
      end
      if (ctl.trig_write && trig_ok) begin
        if (full) begin
          head <= (head == VIW'(MAX_VOICES - 1)) ? '0 : head + VIW'(1);
        end else begin
          count <= count + CW'(1);
        end
      end
      if (mix.ready) begin
        out_valid <= 1'b0;
      end
      if (ctl.finish) begin
        out_valid <= 1'b1;
        count     <= kept;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur   <= req.data;
      acc_l <= '0;
      acc_r <= '0;
      idx   <= '0;
      kept  <= '0;
    end
    if (ctl.voice_latch) begin
      vslot <= voice_rdata[VDW-1:LW];
      vpos  <= voice_rdata[LW-1:0];
    end
    if (ctl.slot_latch) begin
      sbase   <= slot_rdata[SDW-1:LW+1];
      slen    <= slot_rdata[LW:1];
      sstereo <= slot_rdata[0];
    end
    if (ctl.right_read) begin
      lword <= samp_rdata;
    end
    if (ctl.voice_done) begin
      idx <= idx + CW'(1);
      if (active) begin
        acc_l <= sat_add(acc_l, lword);
        acc_r <= sat_add(acc_r, rv);
      end
      if (keep) begin
        kept <= kept + CW'(1);
      end
    end
    if (ctl.finish) begin
      out_data.left_out      <= acc_l;
      out_data.right_out     <= acc_r;
      out_data.voices_active <= svm_pkg::ACT_W'(kept);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_VOICES)) else $error("voice count above capacity");
  a_kept_le_idx: assert property (@(posedge clk) disable iff (rst)
    ctl.voice_done |-> kept <= idx) else $error("compaction overtook the walk");
  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    ctl.finish |=> mix.valid) else $error("finished frame not presented");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    ctl.clr_step |-> !req.ready) else $error("beat taken during slot clearing");
`endif
endmodule
